// ===== rtl/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

  // Map geometry
  localparam int MapBytes = 128;
  localparam int ByteAw   = $clog2(MapBytes);
  localparam int CfgW     = 8;
  localparam int SlotW    = 10;
  localparam int RunW     = 11;
  localparam int SkipW    = 7;
  localparam int BitsPerByte = 8;
  localparam int BitSelW  = $clog2(BitsPerByte);

  typedef enum logic [1:0] {
    OpScan  = 2'd0,
    OpWrite = 2'd1,
    OpTest  = 2'd2,
    OpClear = 2'd3
  } op_e;

  // Control from the sequencer to the run scanner
  typedef struct packed {
    logic             clear;
    logic             step;
    logic [RunW-1:0]  run_len;
    logic [SlotW-1:0] base;
  } scan_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_run_allocator.sv =====
// Bitmap run allocator: first-fit search, single-slot access and clear-all on a slot map.
// Instantiates bra_map_mem and bra_run_scan; imports bra_pkg.
//
// Usage:
//   Requests enter on the in_valid_i / in_ready_o channel with op_i, bit_index_i,
//   write_value_i, run_length_i and skip_bytes_i. Every request yields exactly one
//   result on out_valid_o / out_ready_i carrying found_o, start_index_o, bit_value_o.
//   One request is worked on at a time; in_ready_o is high whenever the sequencer
//   is idle, even while a finished result still sits in the output register.
//   Clear-all and out-of-range write/test go from dispatch straight to finish; write
//   and test pass through an access state (one RAM read, one write-back); scan walks
//   the map bytes one byte per cycle through the single RAM read port.
//   The map size register is written through cfg_we_i / cfg_wdata_i; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Reset clears the map through per-byte valid flops (no sweep), sets the map size
//   to 128 bytes and empties the output register.
//   When the receiver stalls, the result holds in the output register; one more
//   request can be finished behind it and waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_run_allocator
  import bra_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  // Request channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       op_i,
  input  wire logic [SlotW-1:0] bit_index_i,
  input  wire logic             write_value_i,
  input  wire logic [RunW-1:0]  run_length_i,
  input  wire logic [SkipW-1:0] skip_bytes_i,
  // Result channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  found_o,
  output logic      [SlotW-1:0] start_index_o,
  output logic                  bit_value_o
);

  typedef enum logic [4:0] {
    StIdle     = 5'b00001,
    StDispatch = 5'b00010,
    StAccess   = 5'b00100,
    StScan     = 5'b01000,
    StFinish   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic [CfgW-1:0] map_bytes_q;
  logic [CfgW-1:0] lim_bytes;

  // Latched request
  op_e              op_q;
  logic [SlotW-1:0] bit_q;
  logic             wval_q;
  logic [RunW-1:0]  run_len_q;
  logic [SkipW-1:0] skip_q;

  // Scan pointers: a byte read is issued in the cycle before it is processed
  logic [CfgW-1:0] issue_q, issue_d;
  logic [CfgW-1:0] proc_q, proc_d;
  logic            pend_q, pend_d;

  // Result being built and output register
  logic             res_found_q, res_found_d;
  logic [SlotW-1:0] res_start_q, res_start_d;
  logic             res_bit_q, res_bit_d;
  logic             out_valid_q;
  logic             out_found_q;
  logic [SlotW-1:0] out_start_q;
  logic             out_bit_q;

  // Memory and scanner hookup
  logic              mem_clr, mem_we;
  logic [ByteAw-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic [7:0]        bit_mask;
  scan_ctrl_t        scan_ctrl;
  logic              scan_hit;
  logic [SlotW-1:0]  scan_start;

  logic             accept;
  logic             in_range;
  logic             load_out;
  logic [CfgW-1:0]  byte_of_bit;

  // Clamp the map size to the stored capacity
  assign lim_bytes = (map_bytes_q > CfgW'(MapBytes)) ? CfgW'(MapBytes) : map_bytes_q;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign byte_of_bit = CfgW'(bit_q[SlotW-1:BitSelW]);
  assign in_range    = byte_of_bit < lim_bytes;
  assign bit_mask    = 8'(1) << bit_q[BitSelW-1:0];
  assign load_out    = (state_q == StFinish) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_bytes_q <= CfgW'(MapBytes);
    end else if (cfg_we_i) begin
      map_bytes_q <= cfg_wdata_i;
    end
  end

  // Latch the request; a zero run length counts as one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(op_i);
      bit_q     <= bit_index_i;
      wval_q    <= write_value_i;
      run_len_q <= (run_length_i == '0) ? RunW'(1) : run_length_i;
      skip_q    <= skip_bytes_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    proc_d      = proc_q;
    pend_d      = 1'b0;
    res_found_d = res_found_q;
    res_start_d = res_start_q;
    res_bit_d   = res_bit_q;
    mem_clr     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = bit_q[SlotW-1:BitSelW];
    mem_wdata   = wval_q ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
    mem_raddr   = bit_q[SlotW-1:BitSelW];
    scan_ctrl.clear   = 1'b0;
    scan_ctrl.step    = 1'b0;
    scan_ctrl.run_len = run_len_q;
    scan_ctrl.base    = {proc_q[ByteAw-1:0], {BitSelW{1'b0}}};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDispatch;
        end
      end

      StDispatch: begin
        res_found_d = 1'b0;
        res_start_d = '0;
        res_bit_d   = 1'b0;
        unique case (op_q)
          OpClear: begin
            mem_clr = 1'b1;
            state_d = StFinish;
          end
          OpWrite, OpTest: begin
            // Read the byte now; an out-of-range slot answers zero at once
            state_d = in_range ? StAccess : StFinish;
          end
          OpScan: begin
            issue_d         = CfgW'(skip_q);
            proc_d          = CfgW'(skip_q);
            scan_ctrl.clear = 1'b1;
            state_d = (CfgW'(skip_q) < lim_bytes) ? StScan : StFinish;
          end
          default: state_d = StFinish;
        endcase
      end

      StAccess: begin
        if (op_q == OpWrite) begin
          mem_we = 1'b1;
        end else begin
          res_bit_d = mem_rdata[bit_q[BitSelW-1:0]];
        end
        state_d = StFinish;
      end

      StScan: begin
        // Issue the next byte read while the previous one is counted
        mem_raddr = issue_q[ByteAw-1:0];
        if (issue_q < lim_bytes) begin
          issue_d = issue_q + CfgW'(1);
          pend_d  = 1'b1;
        end
        if (pend_q) begin
          scan_ctrl.step = 1'b1;
          proc_d         = proc_q + CfgW'(1);
          if (scan_hit) begin
            res_found_d = 1'b1;
            res_start_d = scan_start;
            state_d     = StFinish;
          end else if (proc_q + CfgW'(1) == lim_bytes) begin
            state_d = StFinish;
          end
        end
      end

      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issue_q     <= '0;
      proc_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      proc_q  <= proc_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= res_found_d;
    res_start_q <= res_start_d;
    res_bit_q   <= res_bit_d;
    if (load_out) begin
      out_found_q <= res_found_q;
      out_start_q <= res_start_q;
      out_bit_q   <= res_bit_q;
    end
  end

  bra_map_mem u_map_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bra_run_scan u_run_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .byte_i  (mem_rdata),
    .hit_o   (scan_hit),
    .start_o (scan_start)
  );

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign start_index_o = out_start_q;
  assign bit_value_o   = out_bit_q;

endmodule

`default_nettype wire

// ===== rtl/bra_map_mem.sv =====
// Bitmap storage: one synchronous byte RAM plus one valid flop per byte.
// A byte whose valid flop is clear reads as zero. Imports bra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bra_map_mem
  import bra_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clr_i,
  input  wire logic              we_i,
  input  wire logic [ByteAw-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic [ByteAw-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  logic [7:0]          mem [MapBytes];
  logic [MapBytes-1:0] valid_q;
  logic [7:0]          rdata_q;
  logic                rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[raddr_i];
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

`default_nettype wire

// ===== rtl/bra_run_scan.sv =====
// Free-run counter: takes one map byte per step and tracks the free run.
// Imports bra_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module bra_run_scan
  import bra_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scan_ctrl_t       ctrl_i,
  input  wire logic [7:0]       byte_i,
  output logic                  hit_o,
  output logic      [SlotW-1:0] start_o
);

  logic [RunW-1:0] count_q, count_d;
  logic [RunW-1:0] start_w;

  // Walk the eight bits of the byte, lowest slot first
  always_comb begin
    count_d = count_q;
    hit_o   = 1'b0;
    start_w = '0;
    for (int k = 0; k < BitsPerByte; k++) begin
      if (!hit_o) begin
        if (byte_i[k]) begin
          count_d = '0;
        end else begin
          count_d = count_d + RunW'(1);
          if (count_d == ctrl_i.run_len) begin
            hit_o   = 1'b1;
            start_w = {1'b0, ctrl_i.base} + RunW'(k) + RunW'(1) - ctrl_i.run_len;
          end
        end
      end
    end
  end

  assign start_o = start_w[SlotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.step) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bra_checker.sv =====
// Port-level checks for bitmap_run_allocator, attached by bind.
// Imports bra_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module bra_checker
  import bra_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic             found_o,
  input wire logic [SlotW-1:0] start_index_o,
  input wire logic             bit_value_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(found_o) && $stable(start_index_o)
      && $stable(bit_value_o))
    else $error("result payload changed while stalled");

  // A miss or a non-scan result carries a zero start slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> start_index_o == '0)
    else $error("start slot set without a found run");

  // Scan and test results never mix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && bit_value_o))
    else $error("found and bit value both set");

  // One request at a time: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .found_o       (found_o),
  .start_index_o (start_index_o),
  .bit_value_o   (bit_value_o)
);

`default_nettype wire
